@@ src/jsu_pkg.sv @@
`timescale 1ns / 1ps
package jsu_pkg;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] position;
    logic [31:0] end_position;
    logic        str_escaped;
    logic        any_escaped;
  } out_item_t;

  typedef enum logic [5:0] {
    PH_AWAIT = 6'b000001,
    PH_BODY  = 6'b000010,
    PH_ESC   = 6'b000100,
    PH_HEX   = 6'b001000,
    PH_UTF8  = 6'b010000,
    PH_DONE  = 6'b100000
  } phase_e;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_NO_QUOTE  = 4'd1;
  localparam logic [3:0] ST_UNTERM    = 4'd2;
  localparam logic [3:0] ST_ESC_CUT   = 4'd3;
  localparam logic [3:0] ST_BAD_ESC   = 4'd4;
  localparam logic [3:0] ST_SHORT_U   = 4'd5;
  localparam logic [3:0] ST_BAD_HEX   = 4'd6;
  localparam logic [3:0] ST_NO_LOW    = 4'd7;
  localparam logic [3:0] ST_BAD_LOW   = 4'd8;
  localparam logic [3:0] ST_LONE_LOW  = 4'd9;
  localparam logic [3:0] ST_CTRL      = 4'd10;
  localparam logic [3:0] ST_BAD_LEAD  = 4'd11;
  localparam logic [3:0] ST_TRUNC     = 4'd12;
  localparam logic [3:0] ST_BAD_CONT  = 4'd13;

  localparam logic [1:0] CLS_END   = 2'd0;
  localparam logic [1:0] CLS_QUOTE = 2'd1;
  localparam logic [1:0] CLS_BSL   = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  // classified item handed from front to back
  typedef struct packed {
    logic [1:0] cls;
    logic [7:0] data_byte;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       simple_esc;
  } cls_item_t;

  localparam int unsigned CLS_W = $bits(cls_item_t);

endpackage

@@ src/jsu_front.sv @@
`timescale 1ns / 1ps
module jsu_front (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  jsu_pkg::in_item_t   in_data_i,
  output logic                push_o,
  output jsu_pkg::cls_item_t  push_data_o,
  input  logic                full_i
);

  logic [7:0] b;

  assign b          = in_data_i.data_byte;
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    push_data_o            = '0;
    push_data_o.data_byte  = b;
    if (in_data_i.cmd) begin
      push_data_o.cls = jsu_pkg::CLS_END;
    end else if (b == 8'h22) begin
      push_data_o.cls = jsu_pkg::CLS_QUOTE;
    end else if (b == 8'h5C) begin
      push_data_o.cls = jsu_pkg::CLS_BSL;
    end else begin
      push_data_o.cls = jsu_pkg::CLS_OTHER;
    end
    if (b >= 8'h30 && b <= 8'h39) begin
      push_data_o.is_hex  = 1'b1;
      push_data_o.hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      push_data_o.is_hex  = 1'b1;
      push_data_o.hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      push_data_o.is_hex  = 1'b1;
      push_data_o.hex_val = 4'(b - 8'h37);
    end
    push_data_o.simple_esc = (b == 8'h22) || (b == 8'h5C) || (b == 8'h2F) ||
                             (b == 8'h62) || (b == 8'h66) || (b == 8'h6E) ||
                             (b == 8'h72) || (b == 8'h74);
  end

endmodule

@@ src/jsu_fifo.sv @@
`timescale 1ns / 1ps
module jsu_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o      = (cnt_q == 2'd2);
  assign pop_valid_o = (cnt_q != 2'd0);
  assign pop_data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

@@ src/jsu_back.sv @@
`timescale 1ns / 1ps
module jsu_back #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         base_offset_i,
  input  logic                item_valid_i,
  input  jsu_pkg::cls_item_t  item_i,
  output logic                item_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jsu_pkg::out_item_t  out_data_o
);

  localparam int unsigned OB = OFFSET_BITS;

  jsu_pkg::phase_e phase_q, phase_d;
  logic [OB-1:0] off_q, off_d, sstart_q, sstart_d, gstart_q, gstart_d, perr_pos_q, perr_pos_d;
  logic [2:0]  grem_q, grem_d;
  logic [3:0]  perr_q, perr_d;
  logic [15:0] cu_q, cu_d;
  logic [7:0]  lo_q, lo_d, hi_q, hi_d;
  logic        tail_q, tail_d, esc_q, esc_d, sticky_q, sticky_d;
  logic        ov_q;
  jsu_pkg::out_item_t od_q;

  logic        emit;
  logic [3:0]  e_st;
  logic [OB-1:0] e_pos, e_end, off1, g2;
  logic [7:0]  b;
  logic [2:0]  rdec;
  logic [15:0] cu_n;
  logic [OB-1:0] base_ext;

  assign base_ext   = OB'({{(OB > 32 ? OB - 32 : 1){1'b0}}, base_offset_i});
  assign item_pop_o = item_valid_i && (!ov_q || !out_stall_i);
  assign b          = item_i.data_byte;
  assign off1       = off_q + OB'(1);
  assign g2         = gstart_q + OB'(2);
  assign rdec       = (grem_q != 3'd0) ? grem_q - 3'd1 : 3'd0;

  always_comb begin
    phase_d = phase_q; off_d = off1; sstart_d = sstart_q; gstart_d = gstart_q;
    grem_d = grem_q; perr_d = perr_q; perr_pos_d = perr_pos_q; cu_d = cu_q;
    lo_d = lo_q; hi_d = hi_q; tail_d = tail_q; esc_d = esc_q; sticky_d = sticky_q;
    emit = 1'b0; e_st = jsu_pkg::ST_OK; e_pos = '0; e_end = '0; cu_n = cu_q;
    if (item_i.cls == jsu_pkg::CLS_END) begin
      unique case (phase_q)
        jsu_pkg::PH_AWAIT: begin emit = 1'b1; e_st = jsu_pkg::ST_NO_QUOTE; e_pos = off_q; end
        jsu_pkg::PH_BODY:  begin emit = 1'b1; e_st = jsu_pkg::ST_UNTERM; e_pos = sstart_q; end
        jsu_pkg::PH_ESC:   begin emit = 1'b1; e_st = jsu_pkg::ST_ESC_CUT; e_pos = gstart_q; end
        jsu_pkg::PH_HEX: begin
          emit = 1'b1; e_pos = gstart_q;
          e_st = tail_q ? jsu_pkg::ST_NO_LOW : jsu_pkg::ST_SHORT_U;
        end
        jsu_pkg::PH_UTF8:  begin emit = 1'b1; e_st = jsu_pkg::ST_TRUNC; e_pos = gstart_q; end
        default: ;
      endcase
      off_d = base_ext; phase_d = jsu_pkg::PH_AWAIT; esc_d = 1'b0;
    end else begin
      unique case (phase_q)
        jsu_pkg::PH_AWAIT: begin
          if (item_i.cls == jsu_pkg::CLS_QUOTE) begin
            phase_d = jsu_pkg::PH_BODY; sstart_d = off1; esc_d = 1'b0;
          end else begin
            emit = 1'b1; e_st = jsu_pkg::ST_NO_QUOTE; e_pos = off_q;
          end
        end
        jsu_pkg::PH_BODY: begin
          if (item_i.cls == jsu_pkg::CLS_QUOTE) begin
            emit = 1'b1; e_st = jsu_pkg::ST_OK; e_pos = sstart_q; e_end = off_q;
          end else if (item_i.cls == jsu_pkg::CLS_BSL) begin
            esc_d = 1'b1; sticky_d = 1'b1; gstart_d = off_q; phase_d = jsu_pkg::PH_ESC;
          end else if (b < 8'h20) begin
            emit = 1'b1; e_st = jsu_pkg::ST_CTRL; e_pos = off_q;
          end else if (b >= 8'h80) begin
            gstart_d = off_q; phase_d = jsu_pkg::PH_UTF8; lo_d = 8'h80; hi_d = 8'hBF;
            if (b >= 8'hC2 && b <= 8'hDF) begin
              grem_d = 3'd1;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
              grem_d = 3'd2;
              if (b == 8'hE0) lo_d = 8'hA0;
              else if (b == 8'hED) hi_d = 8'h9F;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
              grem_d = 3'd3;
              if (b == 8'hF0) lo_d = 8'h90;
              else if (b == 8'hF4) hi_d = 8'h8F;
            end else begin
              emit = 1'b1; e_st = jsu_pkg::ST_BAD_LEAD; e_pos = off_q;
            end
          end
        end
        jsu_pkg::PH_ESC: begin
          if (item_i.simple_esc) begin
            phase_d = jsu_pkg::PH_BODY;
          end else if (b == 8'h75) begin
            grem_d = 3'd4; gstart_d = off1; cu_d = '0; phase_d = jsu_pkg::PH_HEX;
          end else begin
            emit = 1'b1; e_st = jsu_pkg::ST_BAD_ESC; e_pos = off_q;
          end
        end
        jsu_pkg::PH_HEX: begin
          if (tail_q && grem_q >= 3'd5) begin
            if (b != ((grem_q == 3'd6) ? 8'h5C : 8'h75) && perr_q == 4'd0) begin
              perr_d = jsu_pkg::ST_NO_LOW; perr_pos_d = gstart_q;
            end
          end else if (!item_i.is_hex) begin
            if (perr_q == 4'd0) begin perr_d = jsu_pkg::ST_BAD_HEX; perr_pos_d = off_q; end
          end else begin
            cu_n = {cu_q[11:0], item_i.hex_val};
          end
          cu_d = cu_n; grem_d = rdec;
          if (rdec == 3'd0) begin
            if (perr_d != 4'd0) begin
              emit = 1'b1; e_st = perr_d; e_pos = perr_pos_d;
            end else if (tail_q) begin
              if (cu_n < 16'hDC00 || cu_n > 16'hDFFF) begin
                emit = 1'b1; e_st = jsu_pkg::ST_BAD_LOW; e_pos = g2;
              end else begin
                tail_d = 1'b0; phase_d = jsu_pkg::PH_BODY;
              end
            end else if (cu_n >= 16'hD800 && cu_n <= 16'hDBFF) begin
              tail_d = 1'b1; grem_d = 3'd6; gstart_d = off1; cu_d = '0;
            end else if (cu_n >= 16'hDC00 && cu_n <= 16'hDFFF) begin
              emit = 1'b1; e_st = jsu_pkg::ST_LONE_LOW; e_pos = gstart_q;
            end else begin
              phase_d = jsu_pkg::PH_BODY;
            end
          end
        end
        jsu_pkg::PH_UTF8: begin
          if ((b < lo_q || b > hi_q) && perr_q == 4'd0) begin
            perr_d = jsu_pkg::ST_BAD_CONT; perr_pos_d = off_q;
          end
          lo_d = 8'h80; hi_d = 8'hBF; grem_d = rdec;
          if (rdec == 3'd0) begin
            if (perr_d != 4'd0) begin
              emit = 1'b1; e_st = perr_d; e_pos = perr_pos_d;
            end else begin
              phase_d = jsu_pkg::PH_BODY;
            end
          end
        end
        default: ;
      endcase
    end
    if (emit) phase_d = (item_i.cls == jsu_pkg::CLS_END) ? jsu_pkg::PH_AWAIT : jsu_pkg::PH_DONE;
    if (emit || item_i.cls == jsu_pkg::CLS_END) begin
      grem_d = '0; perr_d = '0; perr_pos_d = '0; lo_d = 8'h80; hi_d = 8'hBF; tail_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_AWAIT; off_q <= '0; sstart_q <= '0; gstart_q <= '0;
      grem_q <= '0; perr_q <= '0; perr_pos_q <= '0; cu_q <= '0;
      lo_q <= 8'h80; hi_q <= 8'hBF; tail_q <= 1'b0; esc_q <= 1'b0; sticky_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (item_pop_o) begin
        phase_q <= phase_d; off_q <= off_d; sstart_q <= sstart_d; gstart_q <= gstart_d;
        grem_q <= grem_d; perr_q <= perr_d; perr_pos_q <= perr_pos_d; cu_q <= cu_d;
        lo_q <= lo_d; hi_q <= hi_d; tail_q <= tail_d; esc_q <= esc_d; sticky_q <= sticky_d;
      end
      if (item_pop_o) ov_q <= emit;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o && emit) begin
      od_q.status       <= e_st;
      od_q.position     <= 32'(e_pos);
      od_q.end_position <= 32'(e_end);
      od_q.str_escaped  <= esc_q;
      od_q.any_escaped  <= sticky_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

  a_grem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grem_q <= 3'd6) else $error("group count out of range");
  a_tail_hex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q |-> phase_q == jsu_pkg::PH_HEX) else $error("surrogate tail outside hex");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && out_stall_i |=> ov_q && $stable(od_q)) else $error("result lost");
  a_perr_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    perr_q != 4'd0 |-> grem_q != 3'd0) else $error("stale held error");

endmodule

@@ src/json_string_utf8_validator.sv @@
`timescale 1ns / 1ps
// Checks one JSON string per buffer on a byte stream, one transfer per cycle
// unless the queue is full or the output stalls. A front stage classifies
// each byte, a two-entry queue decouples it from the back state machine, and
// a result register behind the queue holds the single outcome per buffer.
module json_string_utf8_validator #(
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  jsu_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output jsu_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [31:0] base_q;
  logic        push, full, pop_valid, pop;
  jsu_pkg::cls_item_t push_data, pop_data;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? base_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      base_q <= pwdata;
    end
  end

  jsu_front u_front (
    .in_valid_i, .in_stall_o, .in_data_i,
    .push_o(push), .push_data_o(push_data), .full_i(full)
  );

  jsu_fifo #(.WIDTH(jsu_pkg::CLS_W)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .push_data_i(push_data), .full_o(full),
    .pop_valid_o(pop_valid), .pop_i(pop), .pop_data_o(pop_data)
  );

  jsu_back #(.OFFSET_BITS(OFFSET_BITS)) u_back (
    .clk_i, .rst_ni, .base_offset_i(base_q), .item_valid_i(pop_valid),
    .item_i(pop_data), .item_pop_o(pop), .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule
